>>> hdl/u8d_pkg.sv
// ---------------------------------------------------------------------------
// u8d_pkg - shared types and constants for the UTF-8 to UCS-2 decoder
// Byte-class prefixes, payload width and the decode step result record.
// ---------------------------------------------------------------------------
package u8d_pkg;

	localparam int ByteW    = 8;
	localparam int UnitW    = 16;
	localparam int PendW    = 3;
	localparam int PayW     = 6;
	localparam int DataPadW = 8;   // input tdata width, whole bytes
	localparam int UnitPadW = 16;  // output tdata width, whole bytes

	typedef logic [ByteW-1:0] byte_t;
	typedef logic [UnitW-1:0] unit_t;
	typedef logic [PendW-1:0] pend_t;

	// lead prefixes, compared against the byte shifted right
	localparam logic [2:0] Lead2Pfx = 3'h6;  // 110xxxxx
	localparam logic [3:0] Lead3Pfx = 4'he;  // 1110xxxx
	localparam logic [4:0] Lead4Pfx = 5'h1e; // 11110xxx
	localparam logic [5:0] Lead5Pfx = 6'h3e; // 111110xx
	localparam logic [6:0] Lead6Pfx = 7'h7e; // 1111110x
	localparam logic [1:0] ContPfx  = 2'h2;  // 10xxxxxx

	// continuation count loaded by each lead
	localparam pend_t PendLead2 = 3'd1;
	localparam pend_t PendLead3 = 3'd2;
	localparam pend_t PendLead4 = 3'd3;
	localparam pend_t PendLead5 = 3'd4;
	localparam pend_t PendLead6 = 3'd5;
	localparam pend_t PendMax   = PendLead6;

	// outcome of one byte
	typedef struct packed {
		logic  emit;
		pend_t pending;
		unit_t acc;
	} dec_res_t;

endpackage

>>> hdl/u8d_decode.sv
// ---------------------------------------------------------------------------
// u8d_decode - one-byte decode step
// Next pending count, next accumulator and emit flag from a byte and state.
// ---------------------------------------------------------------------------
module u8d_decode (
	input  u8d_pkg::byte_t   data_byte,
	input  logic             last_of_string,
	input  u8d_pkg::pend_t   pending,
	input  u8d_pkg::unit_t   acc,
	output u8d_pkg::dec_res_t res
);

	logic [u8d_pkg::PayW-1:0] cont_pay;
	u8d_pkg::unit_t           cont_add;
	u8d_pkg::pend_t           pend_dec;
	u8d_pkg::unit_t           acc_or;

	assign cont_pay = data_byte[u8d_pkg::PayW-1:0];
	assign pend_dec = pending - u8d_pkg::pend_t'(1);
	assign acc_or   = acc | cont_add;

	// bit position 6*(pending-1); positions at 16 and above fall off
	always_comb begin
		unique case (pending)
			3'd1:    cont_add = u8d_pkg::unit_t'(cont_pay);
			3'd2:    cont_add = {4'd0, cont_pay, 6'd0};
			3'd3:    cont_add = {cont_pay[3:0], 12'd0};
			default: cont_add = '0;
		endcase
	end

	always_comb begin
		res = '{emit: 1'b0, pending: pending, acc: acc};
		if (pending == '0) begin
			if (!data_byte[7]) begin
				res.emit = 1'b1;
				res.acc  = acc;
			end else if (data_byte[7:5] == u8d_pkg::Lead2Pfx) begin
				res.acc     = {5'd0, data_byte[4:0], 6'd0};
				res.pending = u8d_pkg::PendLead2;
			end else if (data_byte[7:4] == u8d_pkg::Lead3Pfx) begin
				res.acc     = {data_byte[3:0], 12'd0};
				res.pending = u8d_pkg::PendLead3;
			end else if (data_byte[7:3] == u8d_pkg::Lead4Pfx) begin
				res.acc     = '0;
				res.pending = u8d_pkg::PendLead4;
			end else if (data_byte[7:2] == u8d_pkg::Lead5Pfx) begin
				res.acc     = '0;
				res.pending = u8d_pkg::PendLead5;
			end else if (data_byte[7:1] == u8d_pkg::Lead6Pfx) begin
				res.acc     = '0;
				res.pending = u8d_pkg::PendLead6;
			end
			// stray continuation, 0xFE, 0xFF: nothing changes
		end else if (data_byte[7:6] == u8d_pkg::ContPfx) begin
			res.acc     = acc_or;
			res.pending = pend_dec;
			res.emit    = (pend_dec == '0);
		end else begin
			// broken sequence; byte is not retried as a lead
			res.pending = '0;
		end
		if (last_of_string) begin
			res.pending = '0;
		end
	end

endmodule

>>> hdl/utf8_to_ucs2_decoder.sv
// ---------------------------------------------------------------------------
// utf8_to_ucs2_decoder - UTF-8 byte stream to 16-bit UCS-2 code units
// Decodes one byte per request; emits a unit for ASCII bytes and on the
// final continuation byte of a sequence, drops malformed input.
// ---------------------------------------------------------------------------
//
//  channel   dir  data                          tlast            tuser
//  s_axis    in   [7:0] data_byte               last_of_string   -
//  m_axis    out  [15:0] code_unit              -                -
//
//  - One byte accepted per cycle while s_axis_tready is high; a unit appears
//    in the cycle after the byte that completes it, set by the single decode
//    step feeding the output register.
//  - Decoder state (pending count, accumulator) updates at the accept edge,
//    so the next byte sees it immediately.
//  - Output register holds a unit until taken; s_axis_tready stays high
//    while it is empty or being taken in the same cycle.
//  - arst_n clears pending count, accumulator and output valid.
//
module utf8_to_ucs2_decoder (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  logic        s_axis_tlast,  // last_of_string

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata   // [15:0] code_unit
);

	u8d_pkg::pend_t    pending_q;
	u8d_pkg::unit_t    acc_q;
	logic              out_valid_q;
	u8d_pkg::unit_t    out_unit_q;
	u8d_pkg::dec_res_t dec;
	logic              in_acc;
	logic              out_unit_sel_acc;

	// output register frees up when empty or drained this cycle
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	u8d_decode u_decode (
		.data_byte      (s_axis_tdata[u8d_pkg::ByteW-1:0]),
		.last_of_string (s_axis_tlast),
		.pending        (pending_q),
		.acc            (acc_q),
		.res            (dec)
	);

	// ASCII passes the byte itself; completed sequences pass the accumulator
	assign out_unit_sel_acc = (pending_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q   <= '0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				pending_q   <= dec.pending;
				acc_q       <= dec.acc;
				out_valid_q <= dec.emit;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload register, no reset needed
	always_ff @(posedge clk) begin
		if (in_acc && dec.emit) begin
			out_unit_q <= out_unit_sel_acc ? dec.acc
				: u8d_pkg::unit_t'(s_axis_tdata[u8d_pkg::ByteW-1:0]);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_unit_q;

	// pending count stays within the longest sequence
	a_pend_range: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= u8d_pkg::PendMax)
		else $error("pending count out of range");

	// end of string leaves the decoder idle
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && s_axis_tlast |=> pending_q == '0)
		else $error("pending not cleared after last byte");

	// ASCII byte while idle comes out unchanged next cycle
	a_ascii_pass: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && pending_q == '0 && !s_axis_tdata[7]
		|=> m_axis_tvalid && m_axis_tdata == {8'd0, $past(s_axis_tdata)})
		else $error("ASCII byte not passed through");

	// stray continuation while idle changes nothing
	a_stray_drop: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && pending_q == '0 && s_axis_tdata[7:6] == u8d_pkg::ContPfx
		|=> pending_q == '0 && $stable(acc_q) && !m_axis_tvalid)
		else $error("stray continuation altered state");

endmodule

>>> sim/utf8_to_ucs2_decoder_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// utf8_to_ucs2_decoder_tb - self-checking bench for the UTF-8 decoder
// Streams UTF-8 bytes into the decoder and checks every code unit against
// a cycle-free predictor of the decode state. A short directed string comes
// first, then random well-formed sequences mixed with broken and stray bytes,
// with random idle on both sides, a stretch without idle and a long output
// stall.
// ---------------------------------------------------------------------------
module utf8_to_ucs2_decoder_tb;

	localparam int StallLimit = 2000;  // cycles without any transfer
	localparam int HoldCycles = 300;   // long output stall
	localparam int IdlePct    = 18;

	// predictor of the decode state plus the queue of units still due
	class unit_scoreboard;
		u8d_pkg::pend_t pend;
		u8d_pkg::unit_t acc;
		u8d_pkg::unit_t units_due[$];
		int    n_bytes, n_used, n_units, n_mism, n_broken, n_tail;

		function new();
			pend = '0;
			acc  = '0;
		endfunction

		// one accepted byte: advance the state, queue a unit if one completes
		function void note_byte(u8d_pkg::byte_t b, bit last);
			int shift;
			n_bytes++;
			if (pend == '0) begin
				if (!b[7]) begin
					units_due.push_back(u8d_pkg::unit_t'(b));
					n_used++;
				end else if (b[7:5] == u8d_pkg::Lead2Pfx) begin
					acc  = u8d_pkg::unit_t'(b[4:0]) << u8d_pkg::PayW;
					pend = u8d_pkg::PendLead2;
					n_used++;
				end else if (b[7:4] == u8d_pkg::Lead3Pfx) begin
					acc  = {b[3:0], 12'h000};
					pend = u8d_pkg::PendLead3;
					n_used++;
				end else if (b[7:3] == u8d_pkg::Lead4Pfx) begin
					acc  = '0;
					pend = u8d_pkg::PendLead4;
					n_used++;
				end else if (b[7:2] == u8d_pkg::Lead5Pfx) begin
					acc  = '0;
					pend = u8d_pkg::PendLead5;
					n_used++;
				end else if (b[7:1] == u8d_pkg::Lead6Pfx) begin
					acc  = '0;
					pend = u8d_pkg::PendLead6;
					n_used++;
				end
				// stray continuation, 0xFE and 0xFF fall through untouched
			end else begin
				n_used++;
				if (b[7:6] == u8d_pkg::ContPfx) begin
					// payload lands at 6 * (remaining - 1); bits above 15 are lost
					shift = (int'(pend) - 1) * u8d_pkg::PayW;
					if (shift < u8d_pkg::UnitW)
						acc = acc | u8d_pkg::unit_t'(32'(b[5:0]) << shift);
					pend = pend - 1'b1;
					if (pend == '0)
						units_due.push_back(acc);
				end else begin
					// broken sequence: accumulator kept, byte not reused as a lead
					pend = '0;
					n_broken++;
				end
			end
			if (last) begin
				if (pend != '0)
					n_tail++;
				pend = '0;
			end
		endfunction

		function void check_unit(u8d_pkg::unit_t got);
			u8d_pkg::unit_t want;
			n_units++;
			if (units_due.size() == 0) begin
				n_mism++;
				if (n_mism <= 10)
					$display("%0t: unexpected unit %h, none due", $time, got);
			end else begin
				want = units_due.pop_front();
				if (got !== want) begin
					n_mism++;
					if (n_mism <= 10)
						$display("%0t: code_unit mismatch: expected %h, got %h",
							$time, want, got);
				end
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // [7:0] data_byte
	logic        s_axis_tlast;   // last_of_string
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;   // [15:0] code_unit

	logic steady;     // no idle on either side
	logic hold_req;   // asks for the long output stall
	logic rx_hold;
	int   idle_cycles;

	unit_scoreboard sb = new();

	utf8_to_ucs2_decoder i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// monitors sample pre-edge values, so ordering within the step is moot
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			sb.note_byte(s_axis_tdata, s_axis_tlast);
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_unit(m_axis_tdata);
	end

	// output side back-pressure
	always @(posedge clk) begin
		if (rx_hold)
			m_axis_tready <= 1'b0;
		else if (steady)
			m_axis_tready <= 1'b1;
		else
			m_axis_tready <= ($urandom_range(99) >= IdlePct);
	end

	// long stall, counted here while the sender keeps pushing
	initial begin
		rx_hold = 1'b0;
		wait (hold_req);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (HoldCycles) @(posedge clk);
		rx_hold <= 1'b0;
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= StallLimit) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// one byte request; returns in the step of its accepting edge
	task automatic send_byte(u8d_pkg::byte_t b, bit last);
		if (!steady) begin
			while ($urandom_range(99) < IdlePct) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	function automatic u8d_pkg::byte_t lead_byte(int len);
		case (len)
			1:       return {1'b0, 7'($urandom)};
			2:       return {u8d_pkg::Lead2Pfx, 5'($urandom)};
			3:       return {u8d_pkg::Lead3Pfx, 4'($urandom)};
			4:       return {u8d_pkg::Lead4Pfx, 3'($urandom)};
			5:       return {u8d_pkg::Lead5Pfx, 2'($urandom)};
			default: return {u8d_pkg::Lead6Pfx, 1'($urandom)};
		endcase
	endfunction

	// any byte that is not a continuation
	function automatic u8d_pkg::byte_t breaker_byte();
		u8d_pkg::byte_t b;
		do b = 8'($urandom); while (b[7:6] == u8d_pkg::ContPfx);
		return b;
	endfunction

	function automatic bit rand_last();
		return $urandom_range(99) < 4;
	endfunction

	task automatic send_seq(int len, int n_cont);
		send_byte(lead_byte(len), rand_last());
		repeat (n_cont)
			send_byte({u8d_pkg::ContPfx, 6'($urandom)}, rand_last());
	endtask

	// mostly well-formed sequences; some cut short, some raw noise
	task automatic send_random_until(int target);
		int pick, len;
		while (sb.n_used < target) begin
			pick = $urandom_range(99);
			if (pick < 25)
				send_seq(1, 0);
			else if (pick < 45)
				send_seq(2, 1);
			else if (pick < 65)
				send_seq(3, 2);
			else if (pick < 75)
				send_seq(4, 3);
			else if (pick < 81)
				send_seq(5, 4);
			else if (pick < 86)
				send_seq(6, 5);
			else if (pick < 93) begin
				len = $urandom_range(6, 2);
				send_seq(len, $urandom_range(len - 2, 0));
				send_byte(breaker_byte(), rand_last());
			end else begin
				send_byte(8'($urandom), rand_last());
			end
		end
	endtask

	// {last_of_string, data_byte}
	logic [8:0] directed [] = '{
		{1'b0, 8'h00}, {1'b1, 8'h7f},                               // ASCII ends, last
		{1'b0, 8'hc2}, {1'b0, 8'ha9},                               // 2-byte
		{1'b0, 8'he2}, {1'b0, 8'h82}, {1'b0, 8'hac},                // 3-byte
		{1'b0, 8'hf0}, {1'b0, 8'h9f}, {1'b0, 8'h98}, {1'b0, 8'h80}, // 4-byte
		{1'b0, 8'hf8}, {1'b0, 8'h88}, {1'b0, 8'h80}, {1'b0, 8'hbf},
		{1'b0, 8'hbf},                                              // 5-byte
		{1'b0, 8'hfd}, {1'b0, 8'hbf}, {1'b0, 8'hbf}, {1'b0, 8'hbf},
		{1'b0, 8'hbf}, {1'b0, 8'hbf},                               // 6-byte
		{1'b0, 8'h80}, {1'b0, 8'hfe}, {1'b0, 8'hff},                // stray, FE, FF
		{1'b0, 8'he2}, {1'b0, 8'h41},                               // broken by ASCII
		{1'b1, 8'hdf}, {1'b0, 8'h80}                                // cut tail, stray
	};

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		steady        = 1'b0;
		hold_req      = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_byte(directed[i][7:0], directed[i][8]);

		send_random_until(300);
		steady <= 1'b1;
		send_random_until(450);
		steady   <= 1'b0;
		hold_req <= 1'b1;
		send_random_until(900);
		s_axis_tvalid <= 1'b0;

		while (sb.units_due.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("summary: %0d bytes (%0d ignored), %0d units checked, %0d mismatches",
			sb.n_bytes, sb.n_bytes - sb.n_used, sb.n_units, sb.n_mism);
		$display("summary: leads of 1 to 6 bytes, %0d broken sequences, %0d cut tails,",
			sb.n_broken, sb.n_tail);
		$display("summary: one %0d-cycle output stall", HoldCycles);
		if (sb.n_mism == 0 && sb.units_due.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

>>> sim.f
hdl/u8d_pkg.sv
hdl/u8d_decode.sv
hdl/utf8_to_ucs2_decoder.sv
sim/utf8_to_ucs2_decoder_tb.sv
